// ----- src/itoa_pkg.sv -----
// Shared types, constants and helpers for the integer to ASCII converter.
package itoa_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam int RADIX_W     = 5;
	localparam int FORMAT_W    = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int DIGIT_W     = 4;
	localparam int CHAR_W      = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_RADIX  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FORMAT = 2'd1;

	localparam logic [RADIX_W-1:0]  RADIX_RESET  = 5'd10;
	localparam logic [RADIX_W-1:0]  RADIX_MIN    = 5'd2;
	localparam logic [RADIX_W-1:0]  RADIX_MAX    = 5'd16;
	localparam logic [FORMAT_W-1:0] FORMAT_RESET = 2'd0;

	localparam int FMT_UNSIGNED_BIT = 0;
	localparam int FMT_LOWER_BIT    = 1;

	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN   = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic done;
		logic q_zero;
	} div_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
		input logic lower);
		logic [CHAR_W-1:0] base;
		base = lower ? CHAR_LOWER_A : CHAR_UPPER_A;
		if (d < DIGIT_TEN) begin
			return CHAR_ZERO + {4'd0, d};
		end
		return base + {4'd0, d - DIGIT_TEN};
	endfunction

endpackage

// ----- src/integer_to_ascii_radix.sv -----
// Top level: integer to ASCII text in a configurable radix, most significant digit first.
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata: value
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: character, tlast: last_char
//  cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// Each digit is the remainder of one division in the bit-serial divider; the characters
// start once the quotient reaches zero and all digits are on the stack, then follow one
// character per cycle while m_axis_tready is high. A new item is taken once the last
// character sits in the output register. Reset returns radix 10, signed upper case.
// cfg_ready is always high.
module integer_to_ascii_radix #(
	parameter  int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF,
	localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [TDATA_W-1:0]                s_axis_tdata,  // value
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [itoa_pkg::CHAR_W-1:0]       m_axis_tdata,  // character
	output logic                              m_axis_tlast,  // last_char
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [itoa_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [itoa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import itoa_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	state_t state_q, state_d;

	logic [RADIX_W-1:0]  radix_q;
	logic [FORMAT_W-1:0] format_q;
	logic [RADIX_W-1:0]  base_q;
	logic                lower_q;
	logic                neg_q;

	logic [DIGIT_W-1:0] stack_q [VALUE_WIDTH];
	logic [CNT_W-1:0]   cnt_q;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;

	logic [VALUE_WIDTH-1:0] in_value;
	logic                   in_neg;
	logic [VALUE_WIDTH-1:0] in_mag;
	logic [RADIX_W-1:0]     eff_radix;

	logic                   div_start;
	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [RADIX_W-1:0]     div_divisor;
	logic [VALUE_WIDTH-1:0] div_quotient;
	logic [DIGIT_W-1:0]     div_rem;
	div_status_t            div_st;

	logic out_free;
	logic accept;
	logic push;
	logic load_sign;
	logic load_digit;

	assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];
	assign in_neg   = !format_q[FMT_UNSIGNED_BIT] && in_value[VALUE_WIDTH-1];
	assign in_mag   = in_neg ? (~in_value + 1'b1) : in_value;

	always_comb begin
		eff_radix = radix_q;
		if (radix_q < RADIX_MIN) eff_radix = RADIX_MIN;
		if (radix_q > RADIX_MAX) eff_radix = RADIX_MAX;
	end

	assign out_free = !out_valid_q || m_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_axis_tvalid) state_d = ST_DIV;
			ST_DIV: begin
				if (div_st.done && div_st.q_zero) state_d = neg_q ? ST_SIGN : ST_EMIT;
			end
			ST_SIGN: if (out_free) state_d = ST_EMIT;
			ST_EMIT: if (out_free && cnt_q == CNT_W'(1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = 1'b0;
		accept        = 1'b0;
		div_start     = 1'b0;
		div_dividend  = div_quotient;
		push          = 1'b0;
		load_sign     = 1'b0;
		load_digit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				accept        = s_axis_tvalid;
				div_start     = s_axis_tvalid;
				div_dividend  = in_mag;
			end
			ST_DIV: begin
				push      = div_st.done;
				div_start = div_st.done && !div_st.q_zero;
			end
			ST_SIGN: load_sign = out_free;
			ST_EMIT: load_digit = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			radix_q     <= RADIX_RESET;
			format_q    <= FORMAT_RESET;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_index == REG_RADIX) radix_q <= cfg_data;
			if (cfg_valid && cfg_index == REG_FORMAT) format_q <= cfg_data[FORMAT_W-1:0];
			if (accept) cnt_q <= '0;
			else if (push) cnt_q <= cnt_q + 1'b1;
			else if (load_digit) cnt_q <= cnt_q - 1'b1;
			if (load_sign || load_digit) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q  <= eff_radix;
			lower_q <= format_q[FMT_LOWER_BIT];
			neg_q   <= in_neg;
		end
		if (push) begin
			stack_q[0] <= div_rem;
			for (int i = 1; i < VALUE_WIDTH; i++) stack_q[i] <= stack_q[i-1];
		end else if (load_digit) begin
			for (int i = 0; i < VALUE_WIDTH - 1; i++) stack_q[i] <= stack_q[i+1];
		end
		if (load_sign) begin
			out_char_q <= CHAR_MINUS;
			out_last_q <= 1'b0;
		end else if (load_digit) begin
			out_char_q <= digit_char(stack_q[0], lower_q);
			out_last_q <= (cnt_q == CNT_W'(1));
		end
	end

	// the first digit starts in the accept cycle, before base_q is loaded
	assign div_divisor = (state_q == ST_IDLE) ? eff_radix : base_q;

	itoa_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quotient),
		.remainder (div_rem),
		.status    (div_st)
	);

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_char_q;
	assign m_axis_tlast  = out_last_q;

endmodule

// ----- src/itoa_divider.sv -----
// Bit-serial restoring divider: one quotient bit per cycle by a radix up to 16.
module itoa_divider #(
	parameter int VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_WIDTH-1:0]        dividend,
	input  logic [itoa_pkg::RADIX_W-1:0]  divisor,
	output logic [VALUE_WIDTH-1:0]        quotient,
	output logic [itoa_pkg::DIGIT_W-1:0]  remainder,
	output itoa_pkg::div_status_t         status
);
	import itoa_pkg::*;

	localparam int CW = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] q_q;
	logic [DIGIT_W-1:0]     r_q;
	logic [CW-1:0]          cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [RADIX_W-1:0] trial;
	logic               ge;
	logic [RADIX_W-1:0] r_next;

	assign trial  = {r_q, q_q[VALUE_WIDTH-1]};
	assign ge     = trial >= divisor;
	assign r_next = ge ? trial - divisor : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
		end else if (busy_q) begin
			q_q <= {q_q[VALUE_WIDTH-2:0], ge};
			r_q <= r_next[DIGIT_W-1:0];
		end
	end

	assign quotient      = q_q;
	assign remainder     = r_q;
	assign status.done   = done_q;
	assign status.q_zero = (q_q == '0);

endmodule
